FILE: src/hsvr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvr_pkg
// Widths, hue offsets and pipeline control types for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int W          = FRAC_BITS + 1;
    localparam int NUM_STAGES = 5;

    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    localparam logic [2:0] K_RED   = 3'd0;
    localparam logic [2:0] K_GREEN = 3'd4;
    localparam logic [2:0] K_BLUE  = 3'd2;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } ctrl_t;

endpackage
`default_nettype wire

FILE: src/hsvr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvr_ctrl
// Valid bits and per-stage load enables for the five-stage pipeline.
// ----------------------------------------------------------------------------
module hsvr_ctrl
    import hsvr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output ctrl_t      ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign ctrl.en   = en;

endmodule
`default_nettype wire

FILE: src/hsvr_channel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvr_channel
// One colour channel: hue ramp, smoothstep, saturation mix and brightness
// scaling over five register stages.
// ----------------------------------------------------------------------------
module hsvr_channel
    import hsvr_pkg::*;
(
    input  wire logic                 clk,
    input  wire ctrl_t                ctrl,
    input  wire logic [2:0]           offset,
    input  wire logic [FRAC_BITS-1:0] hue,
    input  wire logic [W-1:0]         sat_s3,
    input  wire logic [W-1:0]         val_s4,
    output logic      [W-1:0]         result
);

    localparam logic [FRAC_BITS+3:0] SIX   = (FRAC_BITS+4)'(6) << FRAC_BITS;
    localparam logic [FRAC_BITS+2:0] THREE = (FRAC_BITS+3)'(3) << FRAC_BITS;
    localparam logic [FRAC_BITS+1:0] THREE_N = (FRAC_BITS+2)'(3) << FRAC_BITS;
    localparam logic [FRAC_BITS+1:0] ONE_D = (FRAC_BITS+2)'(1) << FRAC_BITS;

    logic [FRAC_BITS+3:0] hue6;
    logic [FRAC_BITS+3:0] sum;
    logic [FRAC_BITS+2:0] x;
    logic [FRAC_BITS+1:0] delta;
    logic [FRAC_BITS+1:0] ramp;
    logic [W-1:0]         t_next;
    logic [W-1:0]         t_reg;

    logic [2*W-1:0]       sq;
    logic [W-1:0]         t2_next;
    logic [W-1:0]         t2_reg;
    logic [FRAC_BITS+1:0] m_next;
    logic [FRAC_BITS+1:0] m_reg;

    logic [W+FRAC_BITS+1:0] cub;
    logic [W+1:0]           cub_sh;
    logic [W-1:0]           sm_next;
    logic [W-1:0]           sm_reg;

    logic [2*W-1:0] mixp;
    logic [W-1:0]   mx_next;
    logic [W-1:0]   mx_reg;

    logic [2*W-1:0] outp;
    logic [W-1:0]   out_next;
    logic [W-1:0]   out_reg;

    always_comb
    begin
        hue6 = ({4'b0, hue} << 2) + ({4'b0, hue} << 1);
        sum  = hue6 + ({1'b0, offset, {FRAC_BITS{1'b0}}});
        if (sum >= SIX)
        begin
            x = (FRAC_BITS+3)'(sum - SIX);
        end
        else
        begin
            x = sum[FRAC_BITS+2:0];
        end
        if (x >= THREE)
        begin
            delta = (FRAC_BITS+2)'(x - THREE);
        end
        else
        begin
            delta = (FRAC_BITS+2)'(THREE - x);
        end
        ramp = (delta > ONE_D) ? (delta - ONE_D) : '0;
        t_next = (ramp > ONE_D) ? ONE : ramp[W-1:0];
    end

    always_comb
    begin
        sq      = t_reg * t_reg;
        t2_next = sq[2*FRAC_BITS:FRAC_BITS];
        m_next  = THREE_N - ({1'b0, t_reg} << 1);
    end

    always_comb
    begin
        cub    = t2_reg * m_reg;
        cub_sh = cub[W+FRAC_BITS+1:FRAC_BITS];
        sm_next = (cub_sh > {2'b0, ONE}) ? ONE : cub_sh[W-1:0];
    end

    always_comb
    begin
        mixp    = sat_s3 * (ONE - sm_reg);
        mx_next = ONE - mixp[2*FRAC_BITS:FRAC_BITS];
    end

    always_comb
    begin
        outp     = mx_reg * val_s4;
        out_next = outp[2*FRAC_BITS:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            t_reg <= t_next;
        end
        if (ctrl.en[1])
        begin
            t2_reg <= t2_next;
            m_reg  <= m_next;
        end
        if (ctrl.en[2])
        begin
            sm_reg <= sm_next;
        end
        if (ctrl.en[3])
        begin
            mx_reg <= mx_next;
        end
        if (ctrl.en[4])
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule
`default_nettype wire

FILE: src/hsv_to_rgb_smooth.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_smooth
// Smooth HSV to RGB conversion; hue in Q0.16, all other values in Q1.16.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// input    in_valid, in_ready   hue, saturation, brightness
// output   out_valid, out_ready red, green, blue
//
// One transfer is taken every cycle while the output is not stalled; each result
// passes through one register stage for the hue ramp and one per multiplier in
// each channel.
// Reset clears only the valid bits; the data registers need none.
// A stall at the output holds every full stage, and a stage accepts new data
// whenever it is empty or the stage after it moves on.
// ----------------------------------------------------------------------------
module hsv_to_rgb_smooth
    import hsvr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [FRAC_BITS-1:0] hue,
    input  wire logic [W-1:0]         saturation,
    input  wire logic [W-1:0]         brightness,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [W-1:0]         red,
    output logic      [W-1:0]         green,
    output logic      [W-1:0]         blue
);

    ctrl_t ctrl;

    logic [W-1:0] sat_clamp;
    logic [W-1:0] val_clamp;
    logic [W-1:0] sat_s1_reg;
    logic [W-1:0] sat_s2_reg;
    logic [W-1:0] sat_s3_reg;
    logic [W-1:0] val_s1_reg;
    logic [W-1:0] val_s2_reg;
    logic [W-1:0] val_s3_reg;
    logic [W-1:0] val_s4_reg;

    hsvr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    assign sat_clamp = (saturation > ONE) ? ONE : saturation;
    assign val_clamp = (brightness > ONE) ? ONE : brightness;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            sat_s1_reg <= sat_clamp;
            val_s1_reg <= val_clamp;
        end
        if (ctrl.en[1])
        begin
            sat_s2_reg <= sat_s1_reg;
            val_s2_reg <= val_s1_reg;
        end
        if (ctrl.en[2])
        begin
            sat_s3_reg <= sat_s2_reg;
            val_s3_reg <= val_s2_reg;
        end
        if (ctrl.en[3])
        begin
            val_s4_reg <= val_s3_reg;
        end
    end

    hsvr_channel u_red (
        .clk    (clk),
        .ctrl   (ctrl),
        .offset (K_RED),
        .hue    (hue),
        .sat_s3 (sat_s3_reg),
        .val_s4 (val_s4_reg),
        .result (red)
    );

    hsvr_channel u_green (
        .clk    (clk),
        .ctrl   (ctrl),
        .offset (K_GREEN),
        .hue    (hue),
        .sat_s3 (sat_s3_reg),
        .val_s4 (val_s4_reg),
        .result (green)
    );

    hsvr_channel u_blue (
        .clk    (clk),
        .ctrl   (ctrl),
        .offset (K_BLUE),
        .hue    (hue),
        .sat_s3 (sat_s3_reg),
        .val_s4 (val_s4_reg),
        .result (blue)
    );

endmodule
`default_nettype wire

FILE: tb/hsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_checker
// Watches both channels of the HSV to RGB converter. Every input transfer is
// converted by an independent fixed-point model and queued; every output
// transfer is compared channel by channel with the oldest queued colour.
// ----------------------------------------------------------------------------
module hsv_checker
    import hsvr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [FRAC_BITS-1:0] hue,
    input  logic [W-1:0]         saturation,
    input  logic [W-1:0]         brightness,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [W-1:0]         red,
    input  logic [W-1:0]         green,
    input  logic [W-1:0]         blue,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [W-1:0] r;
        logic [W-1:0] g;
        logic [W-1:0] b;
    } colour_t;

    colour_t colour_q[$];
    int      fails = 0;
    int      depth = 0;

    assign fail_count = fails;
    assign pending    = depth;

    function automatic logic [W-1:0] shade_channel(input logic [FRAC_BITS-1:0] h,
                                                    input logic [2:0]           k,
                                                    input logic [63:0]          s,
                                                    input logic [63:0]          v);
        logic [63:0] one;
        logic [63:0] three;
        logic [63:0] x;
        logic [63:0] delta;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] sm;
        logic [63:0] mx;
        one   = 64'd1 << FRAC_BITS;
        three = 64'd3 * one;
        x     = (64'(h) * 64'd6 + 64'(k) * one) % (64'd6 * one);
        delta = (x >= three) ? x - three : three - x;
        t     = (delta > one) ? delta - one : 64'd0;
        if (t > one)
        begin
            t = one;
        end
        t2 = (t * t) >> FRAC_BITS;
        sm = (t2 * (three - 64'd2 * t)) >> FRAC_BITS;
        if (sm > one)
        begin
            sm = one;
        end
        mx = one - ((s * (one - sm)) >> FRAC_BITS);
        return W'((mx * v) >> FRAC_BITS);
    endfunction

    function automatic colour_t convert_pixel(input logic [FRAC_BITS-1:0] h,
                                              input logic [W-1:0]         s,
                                              input logic [W-1:0]         v);
        colour_t     c;
        logic [63:0] s_lim;
        logic [63:0] v_lim;
        s_lim = (s > ONE) ? 64'(ONE) : 64'(s);
        v_lim = (v > ONE) ? 64'(ONE) : 64'(v);
        c.r   = shade_channel(h, K_RED, s_lim, v_lim);
        c.g   = shade_channel(h, K_GREEN, s_lim, v_lim);
        c.b   = shade_channel(h, K_BLUE, s_lim, v_lim);
        return c;
    endfunction

    always @(posedge clk)
    begin : watch
        colour_t want;
        int      errs;
        errs = 0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (colour_q.size() == 0)
                begin
                    $error("unexpected result: red %0d, green %0d, blue %0d",
                           red, green, blue);
                    errs++;
                end
                else
                begin
                    want = colour_q.pop_front();
                    if (red !== want.r)
                    begin
                        $error("red mismatch: expected %0d, actual %0d", want.r, red);
                        errs++;
                    end
                    if (green !== want.g)
                    begin
                        $error("green mismatch: expected %0d, actual %0d", want.g, green);
                        errs++;
                    end
                    if (blue !== want.b)
                    begin
                        $error("blue mismatch: expected %0d, actual %0d", want.b, blue);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                colour_q.push_back(convert_pixel(hue, saturation, brightness));
            end
        end
        fails <= fails + errs;
        depth <= colour_q.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the HSV to RGB converter: a directed set of
// boundary pixels, then random pixels under three idle patterns, the last with
// a long output stall, and drains between phases. Checking is done by hsv_checker.
// ----------------------------------------------------------------------------
module tb
    import hsvr_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 567;
    localparam int TAIL_CYCLES = 4 * NUM_STAGES;
    localparam int HOLD_CYCLES = 120;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [FRAC_BITS-1:0] hue;
    logic [W-1:0]         saturation;
    logic [W-1:0]         brightness;
    logic                 out_valid;
    logic                 out_ready;
    logic [W-1:0]         red;
    logic [W-1:0]         green;
    logic [W-1:0]         blue;

    int fail_count;
    int pending;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;
    int cycles    = 0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    always #1 clk = ~clk;

    hsv_to_rgb_smooth dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_pixel(input logic [FRAC_BITS-1:0] h,
                              input logic [W-1:0]         s,
                              input logic [W-1:0]         v);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [W-1:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return ONE;
        end
        if (r < 20)
        begin
            return '0;
        end
        if (r < 35)
        begin
            return W'($urandom);
        end
        return W'($urandom_range(ONE));
    endfunction

    task automatic random_phase(input int s_idle, input int r_idle, input int count);
        send_idle = s_idle;
        recv_idle <= r_idle;
        for (int i = 0; i < count; i++)
        begin
            send_pixel(FRAC_BITS'($urandom), pick_level(), pick_level());
        end
        drain_pipeline();
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        hue        <= '0;
        saturation <= '0;
        brightness <= '0;
        out_ready  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sector boundaries and mid-sector hues at full saturation and brightness, then
        // the extremes of saturation and brightness, including values above one.
        send_pixel(16'd0, ONE, ONE);
        send_pixel(16'd10923, ONE, ONE);
        send_pixel(16'd21845, ONE, ONE);
        send_pixel(16'd32768, ONE, ONE);
        send_pixel(16'd43691, ONE, ONE);
        send_pixel(16'd54613, ONE, ONE);
        send_pixel(16'd65535, ONE, ONE);
        send_pixel(16'd5461, ONE, ONE);
        send_pixel(16'd27307, ONE, ONE);
        send_pixel(16'd1, ONE, ONE);
        send_pixel(16'd12000, '0, ONE);
        send_pixel(16'd12000, ONE, '0);
        send_pixel(16'd12000, '0, '0);
        send_pixel(16'd40000, W'(ONE + 1), ONE);
        send_pixel(16'd40000, '1, ONE);
        send_pixel(16'd40000, ONE, W'(ONE + 1));
        send_pixel(16'd40000, ONE, '1);
        send_pixel(16'hFFFF, '1, '1);
        send_pixel(16'h5555, 17'h0AAAA, 17'h05555);
        send_pixel(16'hAAAA, 17'h05555, 17'h0AAAA);
        send_pixel(16'd30000, W'(1), W'(1));
        send_pixel(16'd30000, W'(ONE - 1), W'(ONE - 1));
        drain_pipeline();

        random_phase(36, 55, PHASE_ITEMS);
        random_phase(55, 36, PHASE_ITEMS);
        hold_req <= 1'b1;
        random_phase(0, 0, PHASE_ITEMS);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
